/* hdl/cdq_pkg.sv */
// Shared codes, defaults and controller/datapath interface types for the ring-buffer deque.
`default_nettype none

package cdq_pkg;

  // default geometry
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths of the channels
  localparam int ACT_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int ERR_W = 3;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ_AT    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RESIZE     = 3'd6;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 3'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 3'd2;
  localparam logic [ERR_W-1:0] ERR_RANGE = 3'd3;
  localparam logic [ERR_W-1:0] ERR_SIZE  = 3'd4;

  // ring read-port selects
  localparam logic [1:0] SEL_FRONT = 2'd0;
  localparam logic [1:0] SEL_BACK  = 2'd1;
  localparam logic [1:0] SEL_IDX   = 2'd2;

  typedef struct packed {
    logic       take;      // latch the input word
    logic       exec;      // apply the action to pointers and store
    logic       fill;      // append one fill entry at the back
    logic       rd_en;     // issue a ring read
    logic [1:0] rd_sel;    // which address to read
    logic       cap_en;    // capture last cycle's read data
    logic [1:0] cap_sel;   // where the read data goes
    logic       load_out;  // load the result registers
  } cmd_t;

  typedef struct packed {
    logic need_fill;  // resize grows the queue
    logic fill_more;  // count still below requested size
  } sts_t;

endpackage

`default_nettype wire

/* hdl/cdq_ctrl.sv */
// Sequencing state machine for the deque: accept, execute, fill, read back, deliver.
`default_nettype none

module cdq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire cdq_pkg::sts_t sts,
  output cdq_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_RD_F  = 3'd3;
  localparam logic [2:0] S_RD_B  = 3'd4;
  localparam logic [2:0] S_RD_I  = 3'd5;
  localparam logic [2:0] S_CAP_I = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_fill ? S_FILL : S_RD_F;
      end
      S_FILL: begin
        if (sts.fill_more) begin
          cmd.fill = 1'b1;
        end else begin
          state_nxt = S_RD_F;
        end
      end
      S_RD_F: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = cdq_pkg::SEL_FRONT;
        state_nxt  = S_RD_B;
      end
      S_RD_B: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = cdq_pkg::SEL_BACK;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = cdq_pkg::SEL_FRONT;
        state_nxt   = S_RD_I;
      end
      S_RD_I: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = cdq_pkg::SEL_IDX;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = cdq_pkg::SEL_BACK;
        state_nxt   = S_CAP_I;
      end
      S_CAP_I: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = cdq_pkg::SEL_IDX;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // wait for the result register to be free
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* hdl/cdq_datapath.sv */
// Deque datapath: ring store, head/tail/count registers, error logic and result registers.
`default_nettype none

module cdq_datapath #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire cdq_pkg::cmd_t                      cmd,
  output cdq_pkg::sts_t                           sts,
  input  wire logic        [cdq_pkg::ACT_W-1:0]   in_action,
  input  wire logic signed [cdq_pkg::VAL_W-1:0]   in_item_value,
  input  wire logic        [cdq_pkg::POS_W-1:0]   in_position_or_size,
  output logic signed      [cdq_pkg::VAL_W-1:0]   out_front_value,
  output logic signed      [cdq_pkg::VAL_W-1:0]   out_back_value,
  output logic signed      [cdq_pkg::VAL_W-1:0]   out_read_value,
  output logic             [cdq_pkg::POS_W-1:0]   out_entry_count,
  output logic                                    out_is_empty,
  output logic                                    out_is_full,
  output logic             [cdq_pkg::ERR_W-1:0]   out_error_code
);

  localparam int VW    = cdq_pkg::VAL_W;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AW    = ((CNT_W > cdq_pkg::POS_W) ? CNT_W : cdq_pkg::POS_W) + 1;
  localparam logic [AW-1:0]    DEPTH_A = AW'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_after(input logic [PTR_W-1:0] p);
    return (p == LAST_P) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_before(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST_P : p - PTR_W'(1);
  endfunction

  // latched input word
  logic [cdq_pkg::ACT_W-1:0] op_r;
  logic [VW-1:0]             val_r;
  logic [cdq_pkg::POS_W-1:0] pos_r;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [cdq_pkg::ERR_W-1:0] err_r, err_nxt;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [DATA_WIDTH-1:0] front_r, back_r, readq_r;
  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] wr_word;
  logic [PTR_W-1:0]      rd_addr;

  logic [AW-1:0] count_a, pos_a, idx_sum, idx_a, drop_d, tail_a, tail_drop;
  logic          is_full, is_empty, read_ok;

  logic [VW-1:0] front_w, back_w, read_w;

  logic signed [VW-1:0]       out_front_r, out_back_r, out_read_r;
  logic [cdq_pkg::POS_W-1:0]  out_count_r;
  logic                       out_empty_r, out_full_r;
  logic [cdq_pkg::ERR_W-1:0]  out_err_r;

  // width conversion between the 32-bit channel and the stored word
  if (DATA_WIDTH <= VW) begin : g_narrow
    assign wr_word = val_r[DATA_WIDTH-1:0];
    if (DATA_WIDTH < VW) begin : g_sext
      assign front_w = {{(VW-DATA_WIDTH){front_r[DATA_WIDTH-1]}}, front_r};
      assign back_w  = {{(VW-DATA_WIDTH){back_r[DATA_WIDTH-1]}}, back_r};
      assign read_w  = {{(VW-DATA_WIDTH){readq_r[DATA_WIDTH-1]}}, readq_r};
    end else begin : g_same
      assign front_w = front_r;
      assign back_w  = back_r;
      assign read_w  = readq_r;
    end
  end else begin : g_wide
    assign wr_word = {{(DATA_WIDTH-VW){1'b0}}, val_r};
    assign front_w = front_r[VW-1:0];
    assign back_w  = back_r[VW-1:0];
    assign read_w  = readq_r[VW-1:0];
  end

  assign count_a  = AW'(count_r);
  assign pos_a    = AW'(pos_r);
  assign tail_a   = AW'(tail_r);
  assign is_full  = (count_a == DEPTH_A);
  assign is_empty = (count_r == '0);
  assign read_ok  = (op_r == cdq_pkg::ACT_READ_AT) && (pos_a < count_a);

  // read index wraps at most once since pos < count <= DEPTH
  assign idx_sum = AW'(head_r) + pos_a;
  assign idx_a   = (idx_sum >= DEPTH_A) ? idx_sum - DEPTH_A : idx_sum;

  // shrink: move tail back by count - size in one step
  assign drop_d    = count_a - pos_a;
  assign tail_drop = (tail_a >= drop_d) ? tail_a - drop_d : tail_a + DEPTH_A - drop_d;

  assign sts.need_fill = (op_r == cdq_pkg::ACT_RESIZE) && (pos_a <= DEPTH_A) &&
                         (pos_a > count_a);
  assign sts.fill_more = (pos_a > count_a);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    wr_en     = 1'b0;
    wr_addr   = tail_r;
    if (cmd.exec) begin
      err_nxt = cdq_pkg::ERR_OK;
      unique case (op_r)
        cdq_pkg::ACT_PUSH_FRONT: begin
          if (is_full) begin
            err_nxt = cdq_pkg::ERR_FULL;
          end else begin
            head_nxt  = ptr_before(head_r);
            wr_en     = 1'b1;
            wr_addr   = ptr_before(head_r);
            count_nxt = count_r + CNT_W'(1);
          end
        end
        cdq_pkg::ACT_PUSH_BACK: begin
          if (is_full) begin
            err_nxt = cdq_pkg::ERR_FULL;
          end else begin
            wr_en     = 1'b1;
            tail_nxt  = ptr_after(tail_r);
            count_nxt = count_r + CNT_W'(1);
          end
        end
        cdq_pkg::ACT_POP_FRONT: begin
          if (is_empty) begin
            err_nxt = cdq_pkg::ERR_EMPTY;
          end else begin
            head_nxt  = ptr_after(head_r);
            count_nxt = count_r - CNT_W'(1);
          end
        end
        cdq_pkg::ACT_POP_BACK: begin
          if (is_empty) begin
            err_nxt = cdq_pkg::ERR_EMPTY;
          end else begin
            tail_nxt  = ptr_before(tail_r);
            count_nxt = count_r - CNT_W'(1);
          end
        end
        cdq_pkg::ACT_READ_AT: begin
          if (!read_ok) begin
            err_nxt = cdq_pkg::ERR_RANGE;
          end
        end
        cdq_pkg::ACT_CLEAR: begin
          head_nxt  = '0;
          tail_nxt  = '0;
          count_nxt = '0;
        end
        cdq_pkg::ACT_RESIZE: begin
          if (pos_a > DEPTH_A) begin
            err_nxt = cdq_pkg::ERR_SIZE;
          end else if (pos_a < count_a) begin
            tail_nxt  = tail_drop[PTR_W-1:0];
            count_nxt = pos_a[CNT_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.fill) begin
      wr_en     = 1'b1;
      tail_nxt  = ptr_after(tail_r);
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      cdq_pkg::SEL_BACK: rd_addr = ptr_before(tail_r);
      cdq_pkg::SEL_IDX:  rd_addr = read_ok ? idx_a[PTR_W-1:0] : '0;
      default:           rd_addr = head_r;
    endcase
  end

  // ring store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r <= err_nxt;
    if (cmd.take) begin
      op_r  <= in_action;
      val_r <= in_item_value;
      pos_r <= in_position_or_size;
    end
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        cdq_pkg::SEL_FRONT: front_r <= rd_data_r;
        cdq_pkg::SEL_BACK:  back_r  <= rd_data_r;
        default:            readq_r <= rd_data_r;
      endcase
    end
    if (cmd.load_out) begin
      out_front_r <= is_empty ? '0 : front_w;
      out_back_r  <= is_empty ? '0 : back_w;
      out_read_r  <= read_ok ? read_w : '0;
      out_count_r <= count_a[cdq_pkg::POS_W-1:0];
      out_empty_r <= is_empty;
      out_full_r  <= is_full;
      out_err_r   <= err_r;
    end
  end

  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;
  assign out_read_value  = out_read_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = out_empty_r;
  assign out_is_full     = out_full_r;
  assign out_error_code  = out_err_r;

endmodule

`default_nettype wire

/* hdl/circular_double_ended_queue_top.sv */
// Top level of the ring-buffer double-ended queue: controller plus datapath.
//
// Usage
//   Input channel (in_valid / in_stall): one word per action, carrying
//   in_action, in_item_value and in_position_or_size. A word is taken on a
//   rising edge with in_valid high and in_stall low.
//   Result channel (out_valid / out_stall): exactly one result word per
//   action: front, back and indexed values, count, empty/full flags, error.
//   Actions are worked one at a time, with in_stall high until the result
//   is loaded. A resize that grows the queue adds a fill step, as the fill
//   writes the ring store one entry a cycle through its single write port.
//   Front, back and index are then read in turn through the one read port.
//   out_valid rises when the result registers are loaded.
//   Stall: the result sits in an output register; while out_stall is held
//   the next action is still taken and worked, and waits before delivery.
//   Reset (rst_n low, synchronous): queue empty, pointers at slot zero, no
//   result pending. Store contents are left as they are.
`default_nettype none

module circular_double_ended_queue_top #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic        [cdq_pkg::ACT_W-1:0]  in_action,
  input  wire logic signed [cdq_pkg::VAL_W-1:0]  in_item_value,
  input  wire logic        [cdq_pkg::POS_W-1:0]  in_position_or_size,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed      [cdq_pkg::VAL_W-1:0]  out_front_value,
  output logic signed      [cdq_pkg::VAL_W-1:0]  out_back_value,
  output logic signed      [cdq_pkg::VAL_W-1:0]  out_read_value,
  output logic             [cdq_pkg::POS_W-1:0]  out_entry_count,
  output logic                                   out_is_empty,
  output logic                                   out_is_full,
  output logic             [cdq_pkg::ERR_W-1:0]  out_error_code
);

  // command and status between sequencer and datapath
  cdq_pkg::cmd_t cmd;
  cdq_pkg::sts_t sts;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // ring store, pointers, error decode and result registers
  cdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_action           (in_action),
    .in_item_value       (in_item_value),
    .in_position_or_size (in_position_or_size),
    .out_front_value     (out_front_value),
    .out_back_value      (out_back_value),
    .out_read_value      (out_read_value),
    .out_entry_count     (out_entry_count),
    .out_is_empty        (out_is_empty),
    .out_is_full         (out_is_full),
    .out_error_code      (out_error_code)
  );

endmodule

`default_nettype wire

/* hdl/cdq_checker.sv */
// Port-level assertions for the deque top level, bound in below.
`default_nettype none

module cdq_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic signed [cdq_pkg::VAL_W-1:0]  out_front_value,
  input wire logic signed [cdq_pkg::VAL_W-1:0]  out_back_value,
  input wire logic signed [cdq_pkg::VAL_W-1:0]  out_read_value,
  input wire logic        [cdq_pkg::POS_W-1:0]  out_entry_count,
  input wire logic                              out_is_empty,
  input wire logic                              out_is_full,
  input wire logic        [cdq_pkg::ERR_W-1:0]  out_error_code
);

  // one action at a time: input is held off right after a word is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again straight after a take");

  // an empty queue reports zero count and zero end values
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |->
      out_entry_count == '0 && out_front_value == '0 && out_back_value == '0)
    else $error("empty flag with non-zero count or end values");

  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_empty && out_is_full))
    else $error("queue shown empty and full at once");

  // a refused action never returns read data
  a_read_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != cdq_pkg::ERR_OK |-> out_read_value == '0)
    else $error("read value on a refused action");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_front_value) && $stable(out_back_value) &&
      $stable(out_read_value) && $stable(out_entry_count) &&
      $stable(out_error_code))
    else $error("stalled result word changed");

endmodule

bind circular_double_ended_queue_top cdq_checker u_cdq_checker (.*);

`default_nettype wire

/* tb/deque_result_checker.sv */
// Checker for the ring-buffer deque: predicts every result word and compares it with the block.
`timescale 1ns / 100ps

module deque_result_checker #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic                              in_stall,
  input  wire logic        [cdq_pkg::ACT_W-1:0]  in_action,
  input  wire logic signed [cdq_pkg::VAL_W-1:0]  in_item_value,
  input  wire logic        [cdq_pkg::POS_W-1:0]  in_position_or_size,
  input  wire logic                              out_valid,
  input  wire logic                              out_stall,
  input  wire logic signed [cdq_pkg::VAL_W-1:0]  out_front_value,
  input  wire logic signed [cdq_pkg::VAL_W-1:0]  out_back_value,
  input  wire logic signed [cdq_pkg::VAL_W-1:0]  out_read_value,
  input  wire logic        [cdq_pkg::POS_W-1:0]  out_entry_count,
  input  wire logic                              out_is_empty,
  input  wire logic                              out_is_full,
  input  wire logic        [cdq_pkg::ERR_W-1:0]  out_error_code,
  output int                                     mismatches,
  output int                                     views_due,
  output int                                     views_checked,
  output int                                     refused_actions
);
  import cdq_pkg::*;

  typedef struct packed {
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] back_value;
    logic signed [VAL_W-1:0] read_value;
    logic        [POS_W-1:0] entry_count;
    logic                    is_empty;
    logic                    is_full;
    logic        [ERR_W-1:0] error_code;
  } queue_view_t;

  // shadow deque
  logic [DATA_WIDTH-1:0] ring [DEPTH];
  int head_slot;
  int tail_slot;
  int held;

  queue_view_t queue_views_due [$];
  int fail_total;
  int checked_total;
  int refused_total;

  function automatic logic signed [VAL_W-1:0] widen(input logic [DATA_WIDTH-1:0] v);
    return $signed(v);
  endfunction

  function automatic void append_entry(input logic signed [VAL_W-1:0] v);
    ring[tail_slot] = DATA_WIDTH'($unsigned(v));
    tail_slot = (tail_slot + 1) % DEPTH;
    held++;
  endfunction

  function automatic void drop_back_entry();
    tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
    held--;
  endfunction

  // applies one action to the shadow deque and returns the view it leaves
  function automatic queue_view_t next_queue_view(input logic [ACT_W-1:0] act,
                                                  input logic signed [VAL_W-1:0] val,
                                                  input logic [POS_W-1:0] pos);
    queue_view_t v;
    v.error_code = ERR_OK;
    v.read_value = '0;
    case (act)
      ACT_PUSH_FRONT: begin
        if (held >= DEPTH) begin
          v.error_code = ERR_FULL;
        end else begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          ring[head_slot] = DATA_WIDTH'($unsigned(val));
          held++;
        end
      end
      ACT_PUSH_BACK: begin
        if (held >= DEPTH) v.error_code = ERR_FULL;
        else append_entry(val);
      end
      ACT_POP_FRONT: begin
        if (held == 0) begin
          v.error_code = ERR_EMPTY;
        end else begin
          head_slot = (head_slot + 1) % DEPTH;
          held--;
        end
      end
      ACT_POP_BACK: begin
        if (held == 0) v.error_code = ERR_EMPTY;
        else drop_back_entry();
      end
      ACT_READ_AT: begin
        if (int'(pos) >= held) v.error_code = ERR_RANGE;
        else v.read_value = widen(ring[(head_slot + int'(pos)) % DEPTH]);
      end
      ACT_CLEAR: begin
        head_slot = 0;
        tail_slot = 0;
        held = 0;
      end
      ACT_RESIZE: begin
        if (int'(pos) > DEPTH) begin
          v.error_code = ERR_SIZE;
        end else begin
          while (held < int'(pos)) append_entry(val);
          while (held > int'(pos)) drop_back_entry();
        end
      end
      default: ;  // unused code: queue untouched
    endcase
    if (held == 0) begin
      v.front_value = '0;
      v.back_value  = '0;
    end else begin
      v.front_value = widen(ring[head_slot]);
      v.back_value  = widen(ring[(tail_slot + DEPTH - 1) % DEPTH]);
    end
    v.entry_count = POS_W'(held);
    v.is_empty    = (held == 0);
    v.is_full     = (held == DEPTH);
    return v;
  endfunction

  always @(posedge clk) begin : watch
    queue_view_t got;
    queue_view_t want;
    if (!rst_n) begin
      head_slot = 0;
      tail_slot = 0;
      held = 0;
      queue_views_due.delete();
    end else begin
      // result side first: a word's own result can never leave on its accepting edge
      if (out_valid && !out_stall) begin
        got = '{out_front_value, out_back_value, out_read_value, out_entry_count,
                out_is_empty, out_is_full, out_error_code};
        if (queue_views_due.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display({"[%0t] unexpected result word: ",
                      "front=%0d back=%0d read=%0d count=%0d err=%0d"},
                     $time, got.front_value, got.back_value, got.read_value,
                     got.entry_count, got.error_code);
        end else begin
          want = queue_views_due[0];
          queue_views_due.delete(0);
          checked_total++;
          if (got !== want) begin
            fail_total++;
            if (fail_total <= 10) begin
              $display({"[%0t] result %0d expected ",
                        "front=%0d back=%0d read=%0d count=%0d e=%0b f=%0b err=%0d"},
                       $time, checked_total, want.front_value, want.back_value,
                       want.read_value, want.entry_count, want.is_empty, want.is_full,
                       want.error_code);
              $display({"[%0t] result %0d actual   ",
                        "front=%0d back=%0d read=%0d count=%0d e=%0b f=%0b err=%0d"},
                       $time, checked_total, got.front_value, got.back_value,
                       got.read_value, got.entry_count, got.is_empty, got.is_full,
                       got.error_code);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = next_queue_view(in_action, in_item_value, in_position_or_size);
        if (want.error_code != ERR_OK) refused_total++;
        queue_views_due.insert(queue_views_due.size(), want);
      end
    end
    mismatches      <= fail_total;
    views_due       <= queue_views_due.size();
    views_checked   <= checked_total;
    refused_actions <= refused_total;
  end

endmodule

/* tb/circular_double_ended_queue_top_test.sv */
// Testbench top for the ring-buffer deque: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module circular_double_ended_queue_top_test;
  import cdq_pkg::*;

  // code seven is not an action; the block must report the queue untouched
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

  localparam int QUIET_LIMIT     = 4000;  // cycles without any handshake
  localparam int SETTLE_CYCLES   = 24;    // latency plus a full-depth fill
  localparam int WORDS_PER_PHASE = 500;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic        [ACT_W-1:0]  in_action = ACT_CLEAR;
  logic signed [VAL_W-1:0]  in_item_value = '0;
  logic        [POS_W-1:0]  in_position_or_size = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [VAL_W-1:0]  out_front_value;
  logic signed [VAL_W-1:0]  out_back_value;
  logic signed [VAL_W-1:0]  out_read_value;
  logic        [POS_W-1:0]  out_entry_count;
  logic                     out_is_empty;
  logic                     out_is_full;
  logic        [ERR_W-1:0]  out_error_code;

  int mismatches;
  int views_due;
  int views_checked;
  int refused_actions;

  int send_idle_pct = 0;  // only touched by the stimulus process
  int recv_idle_pct = 0;  // written with nonblocking assignments
  int words_sent = 0;
  int directed_words = 0;

  circular_double_ended_queue_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_item_value       (in_item_value),
    .in_position_or_size (in_position_or_size),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_front_value     (out_front_value),
    .out_back_value      (out_back_value),
    .out_read_value      (out_read_value),
    .out_entry_count     (out_entry_count),
    .out_is_empty        (out_is_empty),
    .out_is_full         (out_is_full),
    .out_error_code      (out_error_code)
  );

  deque_result_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_item_value       (in_item_value),
    .in_position_or_size (in_position_or_size),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_front_value     (out_front_value),
    .out_back_value      (out_back_value),
    .out_read_value      (out_read_value),
    .out_entry_count     (out_entry_count),
    .out_is_empty        (out_is_empty),
    .out_is_full         (out_is_full),
    .out_error_code      (out_error_code),
    .mismatches          (mismatches),
    .views_due           (views_due),
    .views_checked       (views_checked),
    .refused_actions     (refused_actions)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure: a fresh coin every cycle, so stalls land on any
  // state of the block's schedule.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Offer one word and hold it, unchanged, until the block takes it. Sender
  // gaps come before the word, never while it is on offer.
  task automatic send_word(input logic [ACT_W-1:0] act, input logic signed [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_action           <= act;
    in_item_value       <= val;
    in_position_or_size <= pos;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Hold the sender off until every result word due has been delivered.
  // views_due is registered in the checker, so it trails the checker's queue.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (views_due != 0);
  endtask

  // Watchdog: ends the run if neither channel moves a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, views_due);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int                      roll;
    logic                    fill_bias;
    logic        [ACT_W-1:0] act;
    logic signed [VAL_W-1:0] val;
    logic        [POS_W-1:0] pos;

    fill_bias = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // refusals on an empty queue, the unused code, and a no-change resize
    send_word(ACT_POP_FRONT, 32'sd0, 5'd0);
    send_word(ACT_POP_BACK, 32'sd0, 5'd0);
    send_word(ACT_READ_AT, 32'sd0, 5'd0);
    send_word(ACT_UNUSED, -32'sd1, 5'd31);
    send_word(ACT_RESIZE, 32'sd0, 5'd0);
    // value extremes at both ends; queue becomes -1, min, max, 0
    send_word(ACT_PUSH_BACK, 32'sh7FFF_FFFF, 5'd0);
    send_word(ACT_PUSH_FRONT, 32'sh8000_0000, 5'd0);
    send_word(ACT_PUSH_BACK, 32'sd0, 5'd0);
    send_word(ACT_PUSH_FRONT, -32'sd1, 5'd31);
    send_word(ACT_READ_AT, 32'sd0, 5'd0);
    send_word(ACT_READ_AT, 32'sd0, 5'd3);
    // reads at and well past the count
    send_word(ACT_READ_AT, 32'sd0, 5'd4);
    send_word(ACT_READ_AT, -32'sd1, 5'd31);
    // growing fill up to capacity, then pushes when full
    send_word(ACT_RESIZE, 32'sh5A5A_5A5A, 5'd16);
    send_word(ACT_PUSH_FRONT, 32'sh0BAD_0001, 5'd0);
    send_word(ACT_PUSH_BACK, 32'sh0BAD_0002, 5'd0);
    // resize beyond capacity, just over and at the field maximum
    send_word(ACT_RESIZE, 32'sd7, 5'd17);
    send_word(ACT_RESIZE, 32'sd7, 5'd31);
    send_word(ACT_READ_AT, 32'sd0, 5'd15);
    // shrinking resize drops from the back, then pops empty it
    send_word(ACT_RESIZE, 32'sd0, 5'd2);
    send_word(ACT_POP_BACK, 32'sd0, 5'd0);
    send_word(ACT_POP_FRONT, 32'sd0, 5'd0);
    // clear of a non-empty queue, then a one-entry fill from empty
    send_word(ACT_PUSH_FRONT, 32'sh1234_5678, 5'd0);
    send_word(ACT_CLEAR, 32'sd0, 5'd0);
    send_word(ACT_RESIZE, -32'sd1, 5'd1);
    directed_words = words_sent;
    wait_drained();

    // ---- random part ----
    // Three idling phases. Within each, the action mix swings between a
    // filling bias and a draining bias every 48 words so the count keeps
    // sweeping from empty to full and back.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct <= 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct <= 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n % 48 == 0) fill_bias = ~fill_bias;
        roll = $urandom_range(0, 99);
        if (fill_bias) begin
          if (roll < 30)      act = ACT_PUSH_FRONT;
          else if (roll < 60) act = ACT_PUSH_BACK;
          else if (roll < 68) act = ACT_POP_FRONT;
          else if (roll < 76) act = ACT_POP_BACK;
          else if (roll < 88) act = ACT_READ_AT;
          else if (roll < 90) act = ACT_CLEAR;
          else if (roll < 98) act = ACT_RESIZE;
          else                act = ACT_UNUSED;
        end else begin
          if (roll < 8)       act = ACT_PUSH_FRONT;
          else if (roll < 16) act = ACT_PUSH_BACK;
          else if (roll < 41) act = ACT_POP_FRONT;
          else if (roll < 66) act = ACT_POP_BACK;
          else if (roll < 84) act = ACT_READ_AT;
          else if (roll < 86) act = ACT_CLEAR;
          else if (roll < 96) act = ACT_RESIZE;
          else                act = ACT_UNUSED;
        end
        // mostly random data, with the corner values now and then
        case ($urandom_range(0, 15))
          0:       val = 32'sh7FFF_FFFF;
          1:       val = 32'sh8000_0000;
          2:       val = 32'sd0;
          3:       val = -32'sd1;
          default: val = $signed($urandom);
        endcase
        // index or size mostly legal; one in ten lands past capacity
        if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(17, 31));
        else                           pos = POS_W'($urandom_range(0, 16));
        send_word(act, val, pos);
        // occasional full drain mid-phase: block idles with an empty pipe
        if ($urandom_range(0, 149) == 0) wait_drained();
      end
      wait_drained();
    end

    // let any stray late word show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d action words (%0d directed, the rest random over three idling phases),",
             words_sent, directed_words);
    $display("with %0d result words checked, %0d of them refused actions, %0d mismatches.",
             views_checked, refused_actions, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
